/* rtl/core/b2d_pkg.sv */
// b2d_pkg: shared types, character codes and power-of-ten tables for the
// binary to decimal text converter. No dependencies.
`default_nettype none

package b2d_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned WIDE_W     = 68;
    localparam int unsigned MAX_DIGITS = 20;
    localparam int unsigned NDIG_W     = 5;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic [NDIG_W-1:0]  ndig;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } beat_t;

    function automatic logic [WIDE_W-1:0] pow10(input logic [NDIG_W-1:0] k);
        logic [WIDE_W-1:0] r;
        unique case (k)
            5'd0:    r = 68'd1;
            5'd1:    r = 68'd10;
            5'd2:    r = 68'd100;
            5'd3:    r = 68'd1000;
            5'd4:    r = 68'd10000;
            5'd5:    r = 68'd100000;
            5'd6:    r = 68'd1000000;
            5'd7:    r = 68'd10000000;
            5'd8:    r = 68'd100000000;
            5'd9:    r = 68'd1000000000;
            5'd10:   r = 68'd10000000000;
            5'd11:   r = 68'd100000000000;
            5'd12:   r = 68'd1000000000000;
            5'd13:   r = 68'd10000000000000;
            5'd14:   r = 68'd100000000000000;
            5'd15:   r = 68'd1000000000000000;
            5'd16:   r = 68'd10000000000000000;
            5'd17:   r = 68'd100000000000000000;
            5'd18:   r = 68'd1000000000000000000;
            5'd19:   r = 68'd10000000000000000000;
            5'd20:   r = 68'd100000000000000000000;
            default: r = '0;
        endcase
        return r;
    endfunction

    // d * 10^k; d is a constant at every call site
    function automatic logic [WIDE_W-1:0] pow10_mult(input logic [DIGIT_W-1:0] d,
                                                    input logic [NDIG_W-1:0] k);
        logic [WIDE_W-1:0] p;
        p = pow10(k);
        return p * WIDE_W'(d);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/b2d_front.sv */
// b2d_front: input side; forms the magnitude, sign and digit count of each
// operand and holds up to two classified items. Depends on b2d_pkg.
`default_nettype none

module b2d_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [b2d_pkg::VALUE_W-1:0]   value,
    input  wire logic                          wide,
    input  wire logic                          signed_mode,
    output logic                               item_valid,
    output b2d_pkg::item_t                     item,
    input  wire logic                          item_take
);

    b2d_pkg::item_t              mem_reg [2];
    logic                        wr_ptr_reg, wr_ptr_next;
    logic                        rd_ptr_reg, rd_ptr_next;
    logic [1:0]                  cnt_reg, cnt_next;
    logic                        wr_en;
    logic                        rd_en;
    b2d_pkg::item_t              cls;
    logic [31:0]                 low_neg;

    always_comb
    begin
        cls.neg  = 1'b0;
        low_neg  = 32'd0 - value[31:0];
        if (wide)
        begin
            cls.mag = value;
            if (signed_mode && value[63])
            begin
                cls.neg = 1'b1;
                cls.mag = 64'd0 - value;
            end
        end
        else
        begin
            cls.mag = {32'd0, value[31:0]};
            if (signed_mode && value[31])
            begin
                cls.neg = 1'b1;
                cls.mag = {32'd0, low_neg};
            end
        end
        cls.ndig = 5'd1;
        for (int k = 1; k < b2d_pkg::MAX_DIGITS; k++)
        begin
            if ({4'd0, cls.mag} >= b2d_pkg::pow10(b2d_pkg::NDIG_W'(k)))
            begin
                cls.ndig = cls.ndig + 5'd1;
            end
        end
    end

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("front queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("front queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

/* rtl/core/b2d_back.sv */
// b2d_back: digit unit that turns one classified item into ASCII beats,
// most significant first, into a two-entry result queue. Depends on b2d_pkg.
`default_nettype none

module b2d_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    input  wire b2d_pkg::item_t                item,
    output logic                               item_take,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [b2d_pkg::CHAR_W-1:0]         char_code,
    output logic                               last
);

    logic                               busy_reg, busy_next;
    logic                               sign_reg, sign_next;
    logic [b2d_pkg::NDIG_W-1:0]         pos_reg, pos_next;
    logic [b2d_pkg::VALUE_W-1:0]        mag_reg, mag_next;

    b2d_pkg::beat_t                     q_reg [2];
    logic                               qwr_reg, qwr_next;
    logic                               qrd_reg, qrd_next;
    logic [1:0]                         qcnt_reg, qcnt_next;

    logic                               space;
    logic                               emit;
    logic                               done;
    logic                               out_rd;
    logic [b2d_pkg::DIGIT_W-1:0]        digit;
    logic [b2d_pkg::WIDE_W-1:0]         sel;
    b2d_pkg::beat_t                     beat;

    // digit = number of multiples d*10^pos not above the remainder
    always_comb
    begin
        digit = '0;
        sel   = '0;
        for (int d = 1; d < 10; d++)
        begin
            if ({4'd0, mag_reg} >= b2d_pkg::pow10_mult(b2d_pkg::DIGIT_W'(d), pos_reg))
            begin
                digit = b2d_pkg::DIGIT_W'(d);
                sel   = b2d_pkg::pow10_mult(b2d_pkg::DIGIT_W'(d), pos_reg);
            end
        end
    end

    assign space     = (qcnt_reg != 2'd2);
    assign emit      = busy_reg && space;
    assign done      = emit && !sign_reg && (pos_reg == '0);
    assign item_take = item_valid && (!busy_reg || done);
    assign out_rd    = pop && !empty;

    always_comb
    begin
        if (sign_reg)
        begin
            beat.char_code = b2d_pkg::CHAR_MINUS;
            beat.last      = 1'b0;
        end
        else
        begin
            beat.char_code = b2d_pkg::CHAR_ZERO + {4'd0, digit};
            beat.last      = (pos_reg == '0);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        sign_next = sign_reg;
        pos_next  = pos_reg;
        mag_next  = mag_reg;
        if (emit)
        begin
            if (sign_reg)
            begin
                sign_next = 1'b0;
            end
            else
            begin
                mag_next = mag_reg - sel[b2d_pkg::VALUE_W-1:0];
                if (pos_reg == '0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg - 5'd1;
                end
            end
        end
        if (item_take)
        begin
            busy_next = 1'b1;
            sign_next = item.neg;
            pos_next  = item.ndig - 5'd1;
            mag_next  = item.mag;
        end
    end

    always_comb
    begin
        qwr_next  = emit ? !qwr_reg : qwr_reg;
        qrd_next  = out_rd ? !qrd_reg : qrd_reg;
        qcnt_next = qcnt_reg + 2'(emit) - 2'(out_rd);
    end

    assign empty     = (qcnt_reg == 2'd0);
    assign char_code = q_reg[qrd_reg].char_code;
    assign last      = q_reg[qrd_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            pos_reg  <= '0;
            qwr_reg  <= 1'b0;
            qrd_reg  <= 1'b0;
            qcnt_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            sign_reg <= sign_next;
            pos_reg  <= pos_next;
            qwr_reg  <= qwr_next;
            qrd_reg  <= qrd_next;
            qcnt_reg <= qcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (emit)
        begin
            q_reg[qwr_reg] <= beat;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg < 5'd20))
        else $error("digit position out of range");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !sign_reg) |->
            ({4'd0, mag_reg} < b2d_pkg::pow10(pos_reg + 5'd1)))
        else $error("remainder exceeds current digit span");

    a_more_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !sign_reg && (pos_reg != '0)) |=> busy_reg)
        else $error("item dropped before its last digit");

    a_qcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg != 2'd3)
        else $error("result queue count out of range");
`endif

endmodule

`default_nettype wire

/* rtl/core/binary_to_decimal_text.sv */
// binary_to_decimal_text: top level; joins the classifying front end and the
// digit back end. Depends on b2d_pkg, b2d_front, b2d_back.
`default_nettype none

// Converts a 32- or 64-bit, signed or unsigned operand to decimal ASCII text,
// one character per result beat, most significant first, with last set on
// the final character. A number yields its digits plus one character for a
// minus sign, 1 to 20 characters, from a digit unit that yields one decimal
// digit per cycle while the result queue has room. The front end classifies an
// item in the cycle it is pushed and buffers two items, so the next numbers
// are taken while one is still being written out.
module binary_to_decimal_text (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [b2d_pkg::VALUE_W-1:0]   value,
    input  wire logic                          wide,
    input  wire logic                          signed_mode,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [b2d_pkg::CHAR_W-1:0]         char_code,
    output logic                               last
);

    logic           item_valid;
    logic           item_take;
    b2d_pkg::item_t item;

    b2d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .value       (value),
        .wide        (wide),
        .signed_mode (signed_mode),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    b2d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .char_code  (char_code),
        .last       (last)
    );

endmodule

`default_nettype wire
